@@ sv/implicit_binary_tree_walker_top_defines.svh @@
// Assertion helpers used by the tree walker RTL.
`ifndef IMPLICIT_BINARY_TREE_WALKER_TOP_DEFINES_SVH
`define IMPLICIT_BINARY_TREE_WALKER_TOP_DEFINES_SVH

// Same-cycle check: when the condition holds, the consequence holds too.
`define IBTW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle check: when the condition holds, the consequence holds in the next cycle.
`define IBTW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/ibtw_pkg.sv @@
package ibtw_pkg;

    // Store and stack geometry.
    localparam int NODES          = 1024;
    localparam int INDEX_BITS     = $clog2(NODES);
    localparam int VALUE_BITS     = 8;
    localparam int STACK_DEPTH    = 10;
    localparam int STACK_IDX_BITS = $clog2(STACK_DEPTH);
    localparam int LEVEL_BITS     = $clog2(STACK_DEPTH + 1);

    // Configuration port geometry.
    localparam int REG_IDX_BITS  = 1;
    localparam int PADDR_BITS    = REG_IDX_BITS + 2;
    localparam int PDATA_BITS    = 32;
    localparam int ORDER_BITS    = 2;

    // Register indexes.
    localparam logic [REG_IDX_BITS-1:0] REG_ORDER = 1'b0;

    // Walk orders; the unused code walks in postorder.
    localparam logic [ORDER_BITS-1:0] ORDER_PRE  = 2'd0;
    localparam logic [ORDER_BITS-1:0] ORDER_IN   = 2'd1;
    localparam logic [ORDER_BITS-1:0] ORDER_POST = 2'd2;

    // Operation codes of an input item.
    typedef enum logic [1:0] {
        OP_SET_ROOT  = 2'd0,
        OP_ADD_LEFT  = 2'd1,
        OP_ADD_RIGHT = 2'd2,
        OP_WALK      = 2'd3
    } t_op;

    // Progress of one stack frame.
    typedef enum logic [1:0] {
        PH_ENTER      = 2'd0,
        PH_LEFT_DONE  = 2'd1,
        PH_RIGHT_DONE = 2'd2
    } t_phase;

    typedef struct packed {
        logic [INDEX_BITS-1:0] slot;
        t_phase                phase;
    } t_frame;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PUSH,
        S_SETTLE,
        S_FINISH
    } t_state;

endpackage

@@ sv/implicit_binary_tree_walker_top.sv @@
// Channel   | Direction | Handshake              | Payload
// ----------+-----------+------------------------+-------------------------------------------
// input     | in        | i_in_valid / o_in_stall | i_operation, i_node_index, i_node_value
// result    | out       | o_out_valid / i_out_stall | o_result_index, o_result_value,
//           |           |                        | o_stored_flag, o_walk_last
// config    | in        | APB psel/penable       | paddr, pwdata, prdata, pready
//
// After reset the presence map is swept clear, one slot per cycle, over every slot;
// no item is taken during that sweep.
// A set or add item goes from idle straight to finish. In a walk step, a frame move
// that offers a child passes the settle and push states (the push reads the presence
// memory once) and a pop settle only, so a step's length grows with the tree height.
// One item is worked on at a time; the next one may be taken while the last result
// still sits in the output register, and the block waits only if that register
// is still full when the new result is ready.
`include "implicit_binary_tree_walker_top_defines.svh"

module implicit_binary_tree_walker_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Input item channel.
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [1:0]                           i_operation,
    input  logic [ibtw_pkg::INDEX_BITS-1:0]      i_node_index,
    input  logic [ibtw_pkg::VALUE_BITS-1:0]      i_node_value,
    // Result item channel.
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [ibtw_pkg::INDEX_BITS-1:0]      o_result_index,
    output logic [ibtw_pkg::VALUE_BITS-1:0]      o_result_value,
    output logic                                 o_stored_flag,
    output logic                                 o_walk_last,
    // Configuration port.
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [ibtw_pkg::PADDR_BITS-1:0]      paddr,
    input  logic [ibtw_pkg::PDATA_BITS-1:0]      pwdata,
    output logic [ibtw_pkg::PDATA_BITS-1:0]      prdata,
    output logic                                 pready
);
    import ibtw_pkg::*;

    // Memories.
    logic [VALUE_BITS-1:0] r_node_values [NODES];
    logic                  r_node_valid  [NODES];

    // Sequencer and walk state.
    t_state                r_state, n_state;
    t_frame                r_stack [STACK_DEPTH];
    t_frame                n_stack [STACK_DEPTH];
    logic [LEVEL_BITS-1:0] r_level, n_level;
    logic                  r_active, n_active;
    logic                  r_moved, n_moved;
    logic [INDEX_BITS:0]   r_cand, n_cand;
    logic [INDEX_BITS-1:0] r_clr_idx;
    logic [ORDER_BITS-1:0] r_order;

    // Pending result.
    logic [INDEX_BITS-1:0] r_res_index, n_res_index;
    logic                  r_res_stored, n_res_stored;
    logic                  r_res_last, n_res_last;
    logic                  r_res_visit, n_res_visit;

    // Memory read data.
    logic                  r_vld_rd;
    logic [VALUE_BITS-1:0] r_rd_value;

    // Output register.
    logic                  r_out_valid;
    logic [INDEX_BITS-1:0] r_out_index;
    logic [VALUE_BITS-1:0] r_out_value;
    logic                  r_out_stored;
    logic                  r_out_last;

    // Decoded helpers.
    logic                      in_accept;
    logic                      cfg_write;
    t_op                       op;
    logic [INDEX_BITS:0]       wr_slot;
    logic                      wr_fit;
    logic                      vld_we;
    logic [INDEX_BITS-1:0]     vld_waddr;
    logic                      vld_wdata;
    logic                      val_we;
    logic [STACK_IDX_BITS-1:0] top_idx;
    t_frame                    top;
    logic                      top_visits;
    logic                      push_ok;
    logic                      out_free;
    logic                      level_empty;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign cfg_write   = psel && penable && pwrite && pready
                         && (paddr[PADDR_BITS-1:2] == REG_ORDER);
    assign op          = t_op'(i_operation);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign level_empty = (r_level == '0);

    // Child slot of an add item; set root always writes slot one.
    always_comb begin
        if (op == OP_SET_ROOT) begin
            wr_slot = (INDEX_BITS+1)'(1);
        end else begin
            wr_slot = {i_node_index, (op == OP_ADD_RIGHT)};
        end
        wr_fit = !wr_slot[INDEX_BITS];
    end

    // Top frame of the walk stack and whether its next move is a visit.
    assign top_idx = STACK_IDX_BITS'(r_level - 1'b1);
    assign top     = r_stack[top_idx];

    always_comb begin
        case (r_order)
            ORDER_PRE: top_visits = (top.phase == PH_ENTER);
            ORDER_IN:  top_visits = (top.phase == PH_LEFT_DONE);
            default:   top_visits = (top.phase == PH_RIGHT_DONE);
        endcase
    end

    // A candidate child is pushed if it lies in the store, is present and fits the stack.
    assign push_ok = !r_cand[INDEX_BITS] && r_vld_rd
                     && (r_level < LEVEL_BITS'(STACK_DEPTH));

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_idx == INDEX_BITS'(NODES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    if (op != OP_WALK) begin
                        n_state = S_FINISH;
                    end else if (r_active) begin
                        n_state = S_SETTLE;
                    end else begin
                        n_state = S_PUSH;
                    end
                end
            end
            S_PUSH: begin
                n_state = S_SETTLE;
            end
            S_SETTLE: begin
                if (level_empty || (top_visits && r_moved)) begin
                    n_state = S_FINISH;
                end else if (top.phase != PH_RIGHT_DONE) begin
                    n_state = S_PUSH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // Datapath and memory control for each state.
    always_comb begin
        n_stack      = r_stack;
        n_level      = r_level;
        n_active     = r_active;
        n_moved      = r_moved;
        n_cand       = r_cand;
        n_res_index  = r_res_index;
        n_res_stored = r_res_stored;
        n_res_last   = r_res_last;
        n_res_visit  = r_res_visit;
        vld_we       = 1'b0;
        vld_waddr    = r_clr_idx;
        vld_wdata    = 1'b0;
        val_we       = 1'b0;
        o_in_stall   = 1'b1;

        unique case (r_state)
            S_CLEAR: begin
                vld_we = 1'b1;
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (in_accept) begin
                    if (op != OP_WALK) begin
                        // A write ends any walk in progress.
                        vld_we       = wr_fit;
                        vld_waddr    = wr_slot[INDEX_BITS-1:0];
                        vld_wdata    = 1'b1;
                        val_we       = wr_fit;
                        n_active     = 1'b0;
                        n_level      = '0;
                        n_res_index  = wr_slot[INDEX_BITS-1:0];
                        n_res_stored = wr_fit;
                        n_res_last   = 1'b0;
                        n_res_visit  = 1'b0;
                    end else begin
                        n_moved = 1'b0;
                        if (!r_active) begin
                            // A fresh walk starts by offering the root.
                            n_level = '0;
                            n_cand  = (INDEX_BITS+1)'(1);
                        end
                    end
                end
            end
            S_PUSH: begin
                if (push_ok) begin
                    n_stack[r_level[STACK_IDX_BITS-1:0]] = '{
                        slot:  r_cand[INDEX_BITS-1:0],
                        phase: PH_ENTER
                    };
                    n_level = r_level + 1'b1;
                end
            end
            S_SETTLE: begin
                if (level_empty) begin
                    // Walk finished, or there was no root to start from.
                    n_active     = 1'b0;
                    n_res_last   = 1'b1;
                    n_res_stored = r_moved;
                    n_res_visit  = r_moved;
                    if (!r_moved) begin
                        n_res_index = '0;
                    end
                end else if (top_visits && r_moved) begin
                    n_active     = 1'b1;
                    n_res_last   = 1'b0;
                    n_res_stored = 1'b1;
                    n_res_visit  = 1'b1;
                end else begin
                    // One move of the top frame; the first visiting move is the result.
                    if (top_visits) begin
                        n_moved     = 1'b1;
                        n_res_index = top.slot;
                    end
                    case (top.phase)
                        PH_ENTER: begin
                            n_stack[top_idx].phase = PH_LEFT_DONE;
                            n_cand                 = {top.slot, 1'b0};
                        end
                        PH_LEFT_DONE: begin
                            n_stack[top_idx].phase = PH_RIGHT_DONE;
                            n_cand                 = {top.slot, 1'b1};
                        end
                        default: begin
                            n_level = r_level - 1'b1;
                        end
                    endcase
                end
            end
            S_FINISH: begin
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_level     <= '0;
            r_active    <= 1'b0;
            r_moved     <= 1'b0;
            r_order     <= ORDER_PRE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_moved <= n_moved;
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (cfg_write) begin
                // A new order ends the walk in progress.
                r_order  <= pwdata[ORDER_BITS-1:0];
                r_active <= 1'b0;
                r_level  <= '0;
            end else begin
                r_active <= n_active;
                r_level  <= n_level;
            end
            if (r_state == S_FINISH && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_stack      <= n_stack;
        r_cand       <= n_cand;
        r_res_index  <= n_res_index;
        r_res_stored <= n_res_stored;
        r_res_last   <= n_res_last;
        r_res_visit  <= n_res_visit;
        if (r_state == S_FINISH && out_free) begin
            r_out_index  <= r_res_index;
            r_out_value  <= r_res_visit ? r_rd_value : '0;
            r_out_stored <= r_res_stored;
            r_out_last   <= r_res_last;
        end
    end

    // Presence memory: one write port, registered read of the next candidate.
    always_ff @(posedge i_clk) begin
        if (vld_we) begin
            r_node_valid[vld_waddr] <= vld_wdata;
        end
        r_vld_rd <= r_node_valid[n_cand[INDEX_BITS-1:0]];
    end

    // Value memory: written by set and add items, read at the visited slot.
    always_ff @(posedge i_clk) begin
        if (val_we) begin
            r_node_values[wr_slot[INDEX_BITS-1:0]] <= i_node_value;
        end
        r_rd_value <= r_node_values[r_res_index];
    end

    // Port drives.
    assign o_out_valid    = r_out_valid;
    assign o_result_index = r_out_index;
    assign o_result_value = r_out_value;
    assign o_stored_flag  = r_out_stored;
    assign o_walk_last    = r_out_last;
    assign pready         = 1'b1;
    assign prdata         = (paddr[PADDR_BITS-1:2] == REG_ORDER)
                            ? PDATA_BITS'(r_order) : '0;

    // Checks on the sequencer.
    `IBTW_ASSERT_NOW(a_level_bound, 1'b1, r_level <= LEVEL_BITS'(STACK_DEPTH),
        "walk stack level beyond its depth")
    `IBTW_ASSERT_NEXT(a_accept_leaves_idle, in_accept, r_state != S_IDLE,
        "accepted item did not start the sequencer")
    `IBTW_ASSERT_NOW(a_active_has_frames, (r_state == S_IDLE) && r_active, r_level != '0,
        "walk marked active with an empty stack")
    `IBTW_ASSERT_NOW(a_no_result_in_clear, r_state == S_CLEAR, !o_out_valid,
        "result offered during the presence sweep")

endmodule

@@ tb/tb_implicit_binary_tree_walker_top.sv @@
module tb_implicit_binary_tree_walker_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ibtw_pkg::*;

    // Cycles with no accepted item on either channel before the run is abandoned.
    // The presence sweep after reset, over all 1024 slots, is one such stretch.
    localparam int IDLE_LIMIT = 4000;
    // The fourth order code has no name in the package; it walks in postorder.
    localparam logic [ORDER_BITS-1:0] ORDER_SPARE = 2'd3;
    localparam int PHASE_ITEMS = 95;

    // Shadow of the tree store and walk stack. It predicts one result per item
    // and holds the results still to come.
    class t_tree_walk_scoreboard;
        typedef struct {
            logic [INDEX_BITS-1:0] index;
            logic [VALUE_BITS-1:0] value;
            logic                  stored;
            logic                  last;
        } t_walk_result;

        logic [VALUE_BITS-1:0] node_val [NODES];
        bit                    node_here [NODES];
        t_frame                frames [STACK_DEPTH];
        int unsigned           depth;
        bit                    walking;
        bit                    walk_finished;
        logic [ORDER_BITS-1:0] order;
        t_walk_result          expected_q [$];
        int                    errors;

        function new();
            foreach (node_here[i]) node_here[i] = 1'b0;
            depth = 0;
            walking = 1'b0;
            walk_finished = 1'b0;
            order = ORDER_PRE;
            errors = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function bit is_present(int unsigned slot);
            return slot < NODES && node_here[slot];
        endfunction

        // A child past the store, empty, or needing one frame too many is absent.
        function void push_child(int unsigned slot);
            if (is_present(slot) && depth < STACK_DEPTH) begin
                frames[depth].slot = slot[INDEX_BITS-1:0];
                frames[depth].phase = PH_ENTER;
                depth++;
            end
        endfunction

        function bit visits_next();
            t_phase ph;
            ph = frames[depth-1].phase;
            case (order)
                ORDER_PRE: return ph == PH_ENTER;
                ORDER_IN:  return ph == PH_LEFT_DONE;
                default:   return ph == PH_RIGHT_DONE;
            endcase
        endfunction

        // One move of the top frame; returns the slot of that frame.
        function int unsigned advance();
            int unsigned top;
            int unsigned slot;
            top = depth - 1;
            slot = frames[top].slot;
            case (frames[top].phase)
                PH_ENTER: begin
                    frames[top].phase = PH_LEFT_DONE;
                    push_child(slot * 2);
                end
                PH_LEFT_DONE: begin
                    frames[top].phase = PH_RIGHT_DONE;
                    push_child(slot * 2 + 1);
                end
                default: begin
                    depth--;
                end
            endcase
            return slot;
        endfunction

        // Moves that visit nothing are run until a visit is due or the walk ends.
        function void skip_silent();
            while (depth > 0 && !visits_next())
                void'(advance());
        endfunction

        function void set_order(logic [ORDER_BITS-1:0] v);
            order = v;
            walking = 1'b0;
            depth = 0;
        endfunction

        function void note_item(t_op op, logic [INDEX_BITS-1:0] idx,
                                logic [VALUE_BITS-1:0] val);
            t_walk_result r;
            int unsigned slot;
            r = '{index: '0, value: '0, stored: 1'b0, last: 1'b0};
            if (op != OP_WALK) begin
                // Every write ends the walk in progress.
                if (op == OP_SET_ROOT)
                    slot = 1;
                else
                    slot = idx * 2 + (op == OP_ADD_RIGHT ? 1 : 0);
                if (slot < NODES) begin
                    node_val[slot] = val;
                    node_here[slot] = 1'b1;
                end
                walking = 1'b0;
                depth = 0;
                r.index = slot[INDEX_BITS-1:0];
                r.stored = slot < NODES;
                expected_q.push_back(r);
                return;
            end
            if (!walking) begin
                depth = 0;
                push_child(1);
                skip_silent();
                if (depth == 0) begin
                    // No root: nothing to visit, and the walk is over at once.
                    r.last = 1'b1;
                    walk_finished = 1'b1;
                    expected_q.push_back(r);
                    return;
                end
                walking = 1'b1;
            end
            slot = advance();
            skip_silent();
            r.index = slot[INDEX_BITS-1:0];
            r.value = node_val[slot];
            r.stored = 1'b1;
            r.last = depth == 0;
            if (r.last) walking = 1'b0;
            walk_finished = r.last;
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [INDEX_BITS-1:0] idx, logic [VALUE_BITS-1:0] val,
                                   logic stored, logic last);
            t_walk_result r;
            if (expected_q.size() == 0) begin
                $error("result item with nothing expected: index %0d value %0d", idx, val);
                errors++;
                return;
            end
            r = expected_q.pop_front();
            if (idx !== r.index) begin
                $error("result_index: expected %0d, actual %0d", r.index, idx);
                errors++;
            end
            if (val !== r.value) begin
                $error("result_value: expected %0d, actual %0d", r.value, val);
                errors++;
            end
            if (stored !== r.stored) begin
                $error("stored_flag: expected %0d, actual %0d", r.stored, stored);
                errors++;
            end
            if (last !== r.last) begin
                $error("walk_last: expected %0d, actual %0d", r.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    logic [1:0]             i_operation = OP_SET_ROOT;
    logic [INDEX_BITS-1:0]  i_node_index = '0;
    logic [VALUE_BITS-1:0]  i_node_value = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic [INDEX_BITS-1:0]  o_result_index;
    logic [VALUE_BITS-1:0]  o_result_value;
    logic                   o_stored_flag;
    logic                   o_walk_last;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [PADDR_BITS-1:0]  paddr = '0;
    logic [PDATA_BITS-1:0]  pwdata = '0;
    logic [PDATA_BITS-1:0]  prdata;
    logic                   pready;

    t_tree_walk_scoreboard sb = new();

    int burst_left = 0;
    int idle_cycles = 0;
    int stall_mode = 0;
    int stall_left = 0;
    int items_sent = 0;
    int unsigned cycle_count = 0;

    implicit_binary_tree_walker_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_node_index   (i_node_index),
        .i_node_value   (i_node_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_index (o_result_index),
        .o_result_value (o_result_value),
        .o_stored_flag  (o_stored_flag),
        .o_walk_last    (o_walk_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The receiver switches between stall patterns, each kept for a randomly drawn span.
    always @(posedge i_clk) begin
        cycle_count++;
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(40, 160);
        end
        stall_left--;
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 3) == 0);
            2:       i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= (cycle_count % 8) < 3;
        endcase
    end

    // Result checking and the watchdog on accepted items.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                sb.check_result(o_result_index, o_result_value, o_stored_flag, o_walk_last);
            if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // The sender works in bursts; between bursts it may drop valid for a while.
    task automatic pace();
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    // Offers one item and holds it until the block takes it.
    task automatic send_item(t_op op, logic [INDEX_BITS-1:0] idx, logic [VALUE_BITS-1:0] val);
        pace();
        i_in_valid <= 1'b1;
        i_operation <= op;
        i_node_index <= idx;
        i_node_value <= val;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_item(op, idx, val);
        items_sent++;
    endtask

    task automatic send_walk();
        send_item(OP_WALK, INDEX_BITS'($urandom_range(0, NODES - 1)),
                  VALUE_BITS'($urandom));
    endtask

    // Steps the walk until a step reports its end, with a cap for large trees.
    task automatic walk_to_end();
        int steps;
        steps = 0;
        do begin
            send_walk();
            steps++;
        end while (!sb.walk_finished && steps < 300);
    endtask

    // Stops sending and waits for every expected result.
    task automatic drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes the order register, then reads it back. Called only with no result pending.
    task automatic write_order(logic [ORDER_BITS-1:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_ORDER, 2'b00};
        pwdata <= PDATA_BITS'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_order(v);
        @(posedge i_clk);
        psel <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== PDATA_BITS'(v)) begin
            $error("traversal_order: expected %0d, actual %0d", v, prdata);
            sb.errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Adds a child under a present node near the top, or sets the root if none is found, so the tree stays walkable.
    task automatic grow_tree();
        int tries;
        int unsigned parent;
        tries = 0;
        do begin
            parent = $urandom_range(1, 31);
            tries++;
        end while (!sb.is_present(parent) && tries < 8);
        if (!sb.is_present(parent))
            send_item(OP_SET_ROOT, INDEX_BITS'($urandom), VALUE_BITS'($urandom));
        else
            send_item($urandom_range(0, 1) ? OP_ADD_RIGHT : OP_ADD_LEFT,
                      INDEX_BITS'(parent), VALUE_BITS'($urandom));
    endtask

    // Builds one random path from the root, three to ten levels deep; its deepest children may lie past the store.
    task automatic grow_chain();
        int unsigned slot;
        int unsigned dir;
        int levels;
        if (!sb.is_present(1))
            send_item(OP_SET_ROOT, '0, VALUE_BITS'($urandom));
        slot = 1;
        levels = $urandom_range(3, 10);
        repeat (levels) begin
            dir = $urandom_range(0, 1);
            send_item(dir ? OP_ADD_RIGHT : OP_ADD_LEFT, INDEX_BITS'(slot),
                      VALUE_BITS'($urandom));
            slot = slot * 2 + dir;
        end
    endtask

    initial begin
        logic [ORDER_BITS-1:0] phase_order [8];
        int phase_end;
        int pick;
        phase_order = '{ORDER_IN, ORDER_POST, ORDER_SPARE, ORDER_PRE,
                        ORDER_POST, ORDER_IN, ORDER_SPARE, ORDER_PRE};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_order(ORDER_PRE);

        // Walk on an empty tree, then a small tree with extreme values.
        send_item(OP_WALK, '0, '0);
        send_item(OP_SET_ROOT, 10'd1023, 8'd255);
        send_item(OP_ADD_LEFT, 10'd1, 8'd0);
        send_item(OP_ADD_RIGHT, 10'd1, 8'h5a);
        send_item(OP_ADD_LEFT, 10'd2, 8'h11);
        send_item(OP_ADD_RIGHT, 10'd3, 8'ha5);
        drain();
        repeat (6) send_walk();
        // A write in the middle of a walk ends it; children at and past the end of the store.
        send_item(OP_ADD_LEFT, 10'd1023, 8'hff);
        send_item(OP_ADD_RIGHT, 10'd512, 8'h0f);
        send_item(OP_ADD_RIGHT, 10'd511, 8'hf0);
        // Parent slot zero: its right child is the root itself.
        send_item(OP_ADD_LEFT, 10'd0, 8'h33);
        send_item(OP_ADD_RIGHT, 10'd0, 8'hc3);
        send_walk();
        send_walk();
        // Order changes end the walk in progress.
        drain();
        write_order(ORDER_IN);
        walk_to_end();
        drain();
        write_order(ORDER_POST);
        walk_to_end();
        drain();
        write_order(ORDER_SPARE);
        send_walk();
        send_walk();

        // Random phases: mostly tree growth and walks, some raw noise.
        foreach (phase_order[p]) begin
            drain();
            write_order(phase_order[p]);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                    send_item(OP_SET_ROOT, INDEX_BITS'($urandom), VALUE_BITS'($urandom));
                else if (pick < 48)
                    grow_tree();
                else if (pick < 50)
                    grow_chain();
                else if (pick < 60)
                    send_item(t_op'($urandom_range(0, 3)),
                              INDEX_BITS'($urandom_range(0, NODES - 1)),
                              VALUE_BITS'($urandom));
                else if (pick < 94)
                    repeat ($urandom_range(1, 12)) send_walk();
                else
                    walk_to_end();
            end
        end

        drain();
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
